@@ design/fixed_weight_sparse_sampler_top_defines.svh @@
// assertion macros for the fixed weight sparse sampler
`ifndef FIXED_WEIGHT_SPARSE_SAMPLER_TOP_DEFINES_SVH
`define FIXED_WEIGHT_SPARSE_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWSS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwss: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define FWSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwss: next-cycle check failed");

`endif

@@ design/fwss_pkg.sv @@
// shared constants, types and helpers of the fixed weight sparse sampler
`timescale 1ns / 1ps

package fwss_pkg;

    localparam int MAX_LENGTH  = 16384;
    localparam int MAX_WEIGHT  = 1023;
    localparam int QUEUE_DEPTH = 4;

    localparam int TW_W   = 10;
    localparam int VL_W   = 15;
    localparam int CFG_W  = 15;
    localparam int IDX_W  = 2;
    localparam int WORD_W = 32;
    localparam int POS_W  = 14;
    localparam int CNT_W  = 10;
    localparam int OFS_W  = 6;
    localparam int ROW_BITS = 64;

    localparam int VL_RESET = 12323;

    localparam logic [IDX_W-1:0] REG_TARGET_WEIGHT = 2'd0;
    localparam logic [IDX_W-1:0] REG_VECTOR_LENGTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPLIT_HALVES  = 2'd2;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_WORD  = 1'b1;

    typedef struct packed {
        logic [TW_W-1:0] target_weight;
        logic [VL_W-1:0] vector_length;
        logic            split_halves;
    } cfg_t;

    // classified request as it travels through the queue (row index goes alongside)
    typedef struct packed {
        logic             clear;
        logic             hit;
        logic [POS_W-1:0] position;
        logic             half;
        logic [OFS_W-1:0] offset;
    } cls_t;

    // target saturated to the largest supported weight
    function automatic logic [CNT_W-1:0] eff_target(input logic [TW_W-1:0] tw);
        logic [CNT_W-1:0] res;
        if ({2'b00, tw} > 12'(MAX_WEIGHT))
        begin
            res = CNT_W'(MAX_WEIGHT);
        end
        else
        begin
            res = tw;
        end
        return res;
    endfunction

endpackage

@@ design/fwss_front.sv @@
// front end: range check, half select and bitmap address of each request
`timescale 1ns / 1ps

module fwss_front #(
    parameter int MAX_LENGTH = fwss_pkg::MAX_LENGTH,
    localparam int BIT_W = $clog2(2 * MAX_LENGTH),
    localparam int ROW_W = BIT_W - 6
) (
    input  fwss_pkg::cfg_t                    cfg,
    input  logic                              mode,
    input  logic [fwss_pkg::WORD_W-1:0]       random_word,
    output fwss_pkg::cls_t                    cls,
    output logic [ROW_W-1:0]                  row
);

    localparam int LEN_CAP = (MAX_LENGTH > 32767) ? 32767 : MAX_LENGTH;
    localparam int SUM_W   = (BIT_W > fwss_pkg::VL_W) ? BIT_W : fwss_pkg::VL_W;

    logic [30:0]                 val;
    logic [fwss_pkg::VL_W-1:0]   r;
    logic [fwss_pkg::VL_W:0]     limit;
    logic                        in_range;
    logic                        upper;
    logic [fwss_pkg::VL_W-1:0]   pos_full;
    logic [SUM_W-1:0]            bit_sum;
    logic [BIT_W-1:0]            bit_idx;

    always_comb
    begin
        val = random_word[30:0];
        // saturate length to the bitmap half size
        if (cfg.vector_length > fwss_pkg::VL_W'(LEN_CAP))
        begin
            r = fwss_pkg::VL_W'(LEN_CAP);
        end
        else
        begin
            r = cfg.vector_length;
        end
        limit    = cfg.split_halves ? {r, 1'b0} : {1'b0, r};
        in_range = val < {15'd0, limit};
        upper    = cfg.split_halves && (val >= {16'd0, r});
        pos_full = upper ? (val[fwss_pkg::VL_W-1:0] - r) : val[fwss_pkg::VL_W-1:0];
        bit_sum  = SUM_W'(pos_full) + (upper ? SUM_W'(MAX_LENGTH) : SUM_W'(0));
        bit_idx  = bit_sum[BIT_W-1:0];
    end

    assign cls.clear    = (mode == fwss_pkg::MODE_CLEAR);
    assign cls.hit      = in_range;
    assign cls.position = pos_full[fwss_pkg::POS_W-1:0];
    assign cls.half     = upper;
    assign cls.offset   = bit_idx[fwss_pkg::OFS_W-1:0];
    assign row          = bit_idx[BIT_W-1:fwss_pkg::OFS_W];

endmodule

@@ design/fwss_queue.sv @@
// small request queue between front and back end
`timescale 1ns / 1ps

module fwss_queue #(
    parameter int W     = 8,
    parameter int DEPTH = fwss_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop,
    output logic [W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [W-1:0]      slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ design/fwss_back.sv @@
// back end: bitmap read-modify-write, sample count, clearing sweep, result register
`timescale 1ns / 1ps

module fwss_back #(
    parameter int MAX_LENGTH = fwss_pkg::MAX_LENGTH,
    localparam int BIT_W = $clog2(2 * MAX_LENGTH),
    localparam int ROW_W = BIT_W - 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fwss_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  fwss_pkg::cls_t                q_cls,
    input  logic [ROW_W-1:0]              q_row,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          accepted,
    output logic [fwss_pkg::POS_W-1:0]    position,
    output logic                          half,
    output logic [fwss_pkg::CNT_W-1:0]    set_count,
    output logic                          complete,
    output logic                          sweeping
);

    localparam int ROWS = (2 * MAX_LENGTH + 63) / 64;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [fwss_pkg::ROW_BITS-1:0] mem [ROWS];

    // decide stage
    logic                           a_valid_reg, a_valid_next;
    fwss_pkg::cls_t                 a_cls_reg;
    logic [ROW_W-1:0]               a_row_reg;
    logic [fwss_pkg::ROW_BITS-1:0]  rdata_reg;

    // last row written, covers the write that lands as the next row is read
    logic                           fwd_valid_reg, fwd_valid_next;
    logic [ROW_W-1:0]               fwd_row_reg;
    logic [fwss_pkg::ROW_BITS-1:0]  fwd_data_reg;

    logic [fwss_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           sweep_reg, sweep_next;
    logic [ROW_W-1:0]               sweep_row_reg, sweep_row_next;

    logic                           res_valid_reg, res_valid_next;
    logic                           accepted_reg;
    logic [fwss_pkg::POS_W-1:0]     position_reg;
    logic                           half_reg;
    logic [fwss_pkg::CNT_W-1:0]     set_count_reg;
    logic                           complete_reg;

    logic [fwss_pkg::CNT_W-1:0]     eff_tgt;
    logic [fwss_pkg::ROW_BITS-1:0]  row_cur;
    logic [fwss_pkg::ROW_BITS-1:0]  new_row;
    logic                           done;
    logic                           take_word;
    logic                           a_fire;
    logic                           wr_en;
    logic [ROW_W-1:0]               wr_row;
    logic [fwss_pkg::ROW_BITS-1:0]  wr_data;

    always_comb
    begin
        eff_tgt   = fwss_pkg::eff_target(cfg.target_weight);
        row_cur   = (fwd_valid_reg && (fwd_row_reg == a_row_reg)) ? fwd_data_reg : rdata_reg;
        new_row   = row_cur | (fwss_pkg::ROW_BITS'(1) << a_cls_reg.offset);
        done      = (count_reg >= eff_tgt);
        take_word = !a_cls_reg.clear && a_cls_reg.hit && !done && !row_cur[a_cls_reg.offset];
        a_fire    = a_valid_reg && !sweep_reg && (!res_valid_reg || res_ready);
        // no pop behind a clear: its row read would race the sweep
        q_pop     = q_valid && !sweep_reg && (!a_valid_reg || (a_fire && !a_cls_reg.clear));

        a_valid_next = a_valid_reg;
        if (q_pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (a_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        count_next = count_reg;
        if (a_fire)
        begin
            if (a_cls_reg.clear)
            begin
                count_next = '0;
            end
            else if (take_word)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        sweep_next     = sweep_reg;
        sweep_row_next = sweep_row_reg;
        if (a_fire && a_cls_reg.clear)
        begin
            sweep_next     = 1'b1;
            sweep_row_next = '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_row_reg == LAST_ROW)
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                sweep_row_next = sweep_row_reg + 1'b1;
            end
        end

        fwd_valid_next = fwd_valid_reg;
        if (a_fire && a_cls_reg.clear)
        begin
            fwd_valid_next = 1'b0;
        end
        else if (a_fire && take_word)
        begin
            fwd_valid_next = 1'b1;
        end

        wr_en   = sweep_reg || (a_fire && take_word);
        wr_row  = sweep_reg ? sweep_row_reg : a_row_reg;
        wr_data = sweep_reg ? '0 : new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            count_reg     <= '0;
            sweep_reg     <= 1'b1;
            sweep_row_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            sweep_row_reg <= sweep_row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_cls_reg <= q_cls;
            a_row_reg <= q_row;
        end
        if (a_fire && take_word)
        begin
            fwd_row_reg  <= a_row_reg;
            fwd_data_reg <= new_row;
        end
        if (a_fire)
        begin
            accepted_reg  <= take_word;
            position_reg  <= take_word ? a_cls_reg.position : '0;
            half_reg      <= take_word && a_cls_reg.half;
            set_count_reg <= count_next;
            complete_reg  <= (count_next >= eff_tgt);
        end
    end

    // bitmap: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (q_pop)
        begin
            rdata_reg <= mem[q_row];
        end
    end

    assign res_valid = res_valid_reg;
    assign accepted  = accepted_reg;
    assign position  = position_reg;
    assign half      = half_reg;
    assign set_count = set_count_reg;
    assign complete  = complete_reg;
    assign sweeping  = sweep_reg;

endmodule

@@ design/fixed_weight_sparse_sampler_top.sv @@
// top level of the fixed weight sparse sampler
`timescale 1ns / 1ps

// Fixed weight sparse sampler: builds a bitmap with exactly target_weight distinct set
// bits by rejection sampling a stream of 32-bit random words (top bit dropped). Each
// request (mode 1) offers one word; it is rejected when it lies at or beyond r (2r in
// split mode), when its bit is already set, or when the target is already reached.
// In split mode words from r up to 2r-1 land in the second half at word minus r.
// A mode 0 request clears bitmap and count. Every request yields exactly one result
// carrying accepted, position, half, set_count and complete. Throughput is one word
// request per clock while no sweep runs and the result channel does not stall; the
// bitmap is a 64-bit wide memory with one read-modify-write per word, and a forwarding
// register covers back-to-back hits on the same row. A request passes queue entry, row
// read, decide and register. Clearing sweeps the bitmap one row per cycle: after reset
// and each clear it wipes all 2*MAX_LENGTH/64 rows (512 by default), during which
// no request is taken. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while no request is in flight.

`include "fixed_weight_sparse_sampler_top_defines.svh"

module fixed_weight_sparse_sampler_top #(
    parameter int MAX_LENGTH = fwss_pkg::MAX_LENGTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [fwss_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fwss_pkg::CFG_W-1:0]    cfg_data,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          mode,
    input  logic [fwss_pkg::WORD_W-1:0]   random_word,
    // result channel
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          accepted,
    output logic [fwss_pkg::POS_W-1:0]    position,
    output logic                          half,
    output logic [fwss_pkg::CNT_W-1:0]    set_count,
    output logic                          complete
);

    localparam int BIT_W = $clog2(2 * MAX_LENGTH);
    localparam int ROW_W = BIT_W - 6;
    localparam int QW    = $bits(fwss_pkg::cls_t) + ROW_W;

    // configuration registers
    logic [fwss_pkg::TW_W-1:0] cfg_target_weight_reg;
    logic [fwss_pkg::VL_W-1:0] cfg_vector_length_reg;
    logic                      cfg_split_halves_reg;
    fwss_pkg::cfg_t            cfg;

    // front to queue
    fwss_pkg::cls_t            f_cls;
    logic [ROW_W-1:0]          f_row;
    logic                      q_push_ready;

    // queue to back
    logic                      q_valid;
    logic                      q_pop;
    logic [QW-1:0]             q_data;
    fwss_pkg::cls_t            q_cls;
    logic [ROW_W-1:0]          q_row;

    logic                      sweeping;
    logic [fwss_pkg::VL_W-1:0] pos_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_target_weight_reg <= '0;
            cfg_vector_length_reg <= fwss_pkg::VL_W'(fwss_pkg::VL_RESET);
            cfg_split_halves_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fwss_pkg::REG_TARGET_WEIGHT: cfg_target_weight_reg <= cfg_data[fwss_pkg::TW_W-1:0];
                fwss_pkg::REG_VECTOR_LENGTH: cfg_vector_length_reg <= cfg_data[fwss_pkg::VL_W-1:0];
                fwss_pkg::REG_SPLIT_HALVES:  cfg_split_halves_reg  <= cfg_data[0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign cfg.target_weight = cfg_target_weight_reg;
    assign cfg.vector_length = cfg_vector_length_reg;
    assign cfg.split_halves  = cfg_split_halves_reg;

    // no request is taken while the bitmap is being swept clear
    assign req_ready = q_push_ready && !sweeping;

    // classify: range check, half select, row and bit offset
    fwss_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .cfg         (cfg),
        .mode        (mode),
        .random_word (random_word),
        .cls         (f_cls),
        .row         (f_row)
    );

    // decouples request intake from the bitmap pipeline
    fwss_queue #(
        .W     (QW),
        .DEPTH (fwss_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid && !sweeping),
        .push_ready (q_push_ready),
        .push_data  ({f_cls, f_row}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign {q_cls, q_row} = q_data;

    // bitmap update, count, clear sweep and result register
    fwss_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cls     (q_cls),
        .q_row     (q_row),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .accepted  (accepted),
        .position  (position),
        .half      (half),
        .set_count (set_count),
        .complete  (complete),
        .sweeping  (sweeping)
    );

    assign pos_ext = {1'b0, position};

    // an accepted word always leaves a nonzero count
    `FWSS_ASSERT_SAME(a_acc_count, res_valid && accepted, set_count != '0)
    // an accepted position lies inside its half
    `FWSS_ASSERT_SAME(a_acc_range, res_valid && accepted, pos_ext < cfg_vector_length_reg)
    // the sweep blocks the decide stage, so no new result appears
    `FWSS_ASSERT_NEXT(a_sweep_quiet, sweeping && !res_valid, !res_valid)

endmodule
